// ===== rtl/vlsp_pkg.sv =====
// shared types, constants and control bundles of the voice link sender
package vlsp_pkg;

  localparam int TIME_W     = 32;
  localparam int CFG_W      = 32;
  localparam int MS_W       = 16;
  localparam int CAP_W      = 11;
  localparam int LEN_W      = 12;
  localparam int ID_W       = 16;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W      = $clog2(MAX_RESULTS);

  localparam logic [CAP_W-1:0] CAP_MIN     = 11'd64;
  localparam logic [CAP_W-1:0] MAX_PAYLOAD = 11'd1024;
  localparam logic [CAP_W-1:0] REQ_LEN     = 11'd4;

  // reset values of the registers
  localparam logic [MS_W-1:0]  LIFESIGN_RST = 16'd5000;
  localparam logic [MS_W-1:0]  REQ_TO_RST   = 16'd500;
  localparam logic [CAP_W-1:0] CAP_RST      = 11'd1024;

  typedef enum logic [1:0] {
    REG_LIFESIGN = 2'd0,
    REG_REQ_TO   = 2'd1,
    REG_CAPACITY = 2'd2,
    REG_SESSION  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_PEER     = 3'd1,
    OP_RX       = 3'd2,
    OP_AUDIO    = 3'd3,
    OP_SHUTDOWN = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    LS_IDLE       = 2'd0,
    LS_INITIAL    = 2'd1,
    LS_REQUESTING = 2'd2,
    LS_READY      = 2'd3
  } link_t;

  typedef enum logic [1:0] {
    RX_GRANT = 2'd0,
    RX_DENY  = 2'd1,
    RX_PONG  = 2'd2,
    RX_OTHER = 2'd3
  } rx_kind_t;

  typedef enum logic [1:0] {
    SEND_NONE    = 2'd0,
    SEND_REQUEST = 2'd1,
    SEND_PING    = 2'd2,
    SEND_VOICE   = 2'd3
  } send_kind_t;

  typedef enum logic [1:0] {
    RES_REQ   = 2'd0,
    RES_PING  = 2'd1,
    RES_RX    = 2'd2,
    RES_VOICE = 2'd3
  } res_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TICK_SUM,
    ST_TICK_CMP,
    ST_EMIT_REQ,
    ST_EMIT_PING,
    ST_EMIT_RX,
    ST_DIV,
    ST_AUDIO
  } ctl_state_t;

  typedef struct packed {
    logic     load;
    logic     set_initial;
    logic     set_idle;
    logic     tick_sum;
    logic     tick_cmp;
    logic     div_start;
    logic     emit;
    res_sel_t sel;
  } cmd_t;

  typedef struct packed {
    op_t   opcode;
    link_t link;
    logic  alive;
    logic  audio_ok;
    logic  ping_fire;
    logic  div_done;
    logic  slot_free;
    logic  voice_last;
  } sts_t;

endpackage

// ===== rtl/vlsp_div.sv =====
// restoring remainder unit, one quotient bit per cycle
module vlsp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [vlsp_pkg::CAP_W-1:0] dividend,
  input  logic [vlsp_pkg::CAP_W-1:0] divisor,
  output logic                       done,
  output logic [vlsp_pkg::CAP_W-1:0] remainder
);

  localparam int STEPS = vlsp_pkg::CAP_W;
  localparam int SC_W  = $clog2(STEPS + 1);

  logic                       busy_r;
  logic                       done_r;
  logic [SC_W-1:0]            cnt_r;
  logic [vlsp_pkg::CAP_W-1:0] dvd_r;
  logic [vlsp_pkg::CAP_W-1:0] rem_r;
  logic [vlsp_pkg::CAP_W:0]   trial;
  logic [vlsp_pkg::CAP_W:0]   diff;

  assign trial = {rem_r, dvd_r[vlsp_pkg::CAP_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= SC_W'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == SC_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[vlsp_pkg::CAP_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_r <= diff[vlsp_pkg::CAP_W-1:0];
      end else begin
        rem_r <= trial[vlsp_pkg::CAP_W-1:0];
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/vlsp_dp.sv =====
// datapath: registers, link state, timers, packetizer and result register
module vlsp_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vlsp_pkg::cmd_t                    cmd,
  output vlsp_pkg::sts_t                    sts,
  input  logic [2:0]                        in_opcode,
  input  logic [vlsp_pkg::MS_W-1:0]         in_elapsed_ms,
  input  logic [1:0]                        in_rx_kind,
  input  logic [vlsp_pkg::ID_W-1:0]         in_rx_sender_id,
  input  logic [vlsp_pkg::LEN_W-1:0]        in_audio_length,
  input  logic [vlsp_pkg::CAP_W-1:0]        in_frame_size,
  input  logic                              cfg_valid,
  input  logic [1:0]                        cfg_index,
  input  logic [vlsp_pkg::CFG_W-1:0]        cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_send_kind,
  output logic [vlsp_pkg::ID_W-1:0]         out_sender_id,
  output logic [vlsp_pkg::TIME_W-1:0]       out_packet_stamp,
  output logic [vlsp_pkg::CAP_W-1:0]        out_payload_length,
  output logic [vlsp_pkg::LEN_W-1:0]        out_payload_offset,
  output logic [vlsp_pkg::CFG_W-1:0]        out_request_word,
  output logic                              out_handled,
  output logic                              out_last
);

  localparam int TW = vlsp_pkg::TIME_W;

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
                                            input logic [vlsp_pkg::MS_W-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {{(TW + 1 - vlsp_pkg::MS_W){1'b0}}, b};
    return s[TW] ? {TW{1'b1}} : s[TW-1:0];
  endfunction

  // configuration
  logic [vlsp_pkg::MS_W-1:0]  life_r;
  logic [vlsp_pkg::MS_W-1:0]  req_to_r;
  logic [vlsp_pkg::CAP_W-1:0] cap_r;
  logic [vlsp_pkg::CFG_W-1:0] session_r;

  // latched item
  logic [2:0]                 opcode_r;
  logic [vlsp_pkg::MS_W-1:0]  dt_r;
  logic [1:0]                 kind_r;
  logic [vlsp_pkg::ID_W-1:0]  sid_r;
  logic [vlsp_pkg::LEN_W-1:0] alen_r;
  logic [vlsp_pkg::CAP_W-1:0] fs_r;

  // protocol state
  vlsp_pkg::link_t            link_r, link_nxt;
  logic                       alive_r, alive_nxt;
  logic [vlsp_pkg::ID_W-1:0]  id_r, id_nxt;
  logic [TW-1:0]              stamp_r, stamp_nxt;
  logic [TW-1:0]              ping_r, ping_nxt;
  logic [TW-1:0]              pong_r, pong_nxt;
  logic [TW-1:0]              respond_r, respond_nxt;

  // packetizer
  logic [vlsp_pkg::CAP_W-1:0] chunk_r;
  logic [vlsp_pkg::LEN_W-1:0] rem_len_r;
  logic [vlsp_pkg::LEN_W-1:0] pos_r;
  logic [vlsp_pkg::CNT_W-1:0] cnt_r;

  // result register
  logic                       out_valid_r;
  logic [1:0]                 kind_out_r;
  logic [vlsp_pkg::ID_W-1:0]  sid_out_r;
  logic [TW-1:0]              stamp_out_r;
  logic [vlsp_pkg::CAP_W-1:0] len_out_r;
  logic [vlsp_pkg::LEN_W-1:0] off_out_r;
  logic [vlsp_pkg::CFG_W-1:0] word_out_r;
  logic                       handled_out_r;
  logic                       last_out_r;

  logic [vlsp_pkg::CAP_W-1:0] cap_cl;
  logic [vlsp_pkg::CAP_W-1:0] div_rem;
  logic                       div_done;
  logic [TW+2:0]              ping_x5;
  logic                       ping_fire;
  logic                       rx_handled;
  logic [vlsp_pkg::LEN_W-1:0] plen;
  logic [vlsp_pkg::LEN_W-1:0] rem_after;
  logic                       voice_last;
  logic                       slot_free;

  always_comb begin
    if (cap_r < vlsp_pkg::CAP_MIN) begin
      cap_cl = vlsp_pkg::CAP_MIN;
    end else if (cap_r > vlsp_pkg::MAX_PAYLOAD) begin
      cap_cl = vlsp_pkg::MAX_PAYLOAD;
    end else begin
      cap_cl = cap_r;
    end
  end

  vlsp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (cap_cl),
    .divisor   (fs_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign ping_x5   = {1'b0, ping_r, 2'b00} + {3'b000, ping_r};
  assign ping_fire = ping_x5 > {{(TW + 3 - vlsp_pkg::MS_W){1'b0}}, life_r};

  assign rx_handled =
      (link_r == vlsp_pkg::LS_REQUESTING &&
       (kind_r == vlsp_pkg::RX_GRANT || kind_r == vlsp_pkg::RX_DENY)) ||
      (link_r == vlsp_pkg::LS_READY && kind_r == vlsp_pkg::RX_PONG && sid_r == id_r);

  assign plen       = ({1'b0, chunk_r} < rem_len_r) ? {1'b0, chunk_r} : rem_len_r;
  assign rem_after  = rem_len_r - plen;
  assign voice_last = (rem_after < {1'b0, fs_r}) ||
                      (cnt_r == vlsp_pkg::CNT_W'(vlsp_pkg::MAX_RESULTS - 1));
  assign slot_free  = !out_valid_r || out_ready;

  always_comb begin
    sts.opcode     = vlsp_pkg::op_t'(opcode_r);
    sts.link       = link_r;
    sts.alive      = alive_r;
    sts.audio_ok   = (fs_r != '0) && (fs_r <= cap_cl) && ({1'b0, fs_r} <= alen_r);
    sts.ping_fire  = ping_fire;
    sts.div_done   = div_done;
    sts.slot_free  = slot_free;
    sts.voice_last = voice_last;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      life_r    <= vlsp_pkg::LIFESIGN_RST;
      req_to_r  <= vlsp_pkg::REQ_TO_RST;
      cap_r     <= vlsp_pkg::CAP_RST;
      session_r <= '0;
    end else if (cfg_valid) begin
      case (vlsp_pkg::reg_idx_t'(cfg_index))
        vlsp_pkg::REG_LIFESIGN: life_r    <= cfg_data[vlsp_pkg::MS_W-1:0];
        vlsp_pkg::REG_REQ_TO:   req_to_r  <= cfg_data[vlsp_pkg::MS_W-1:0];
        vlsp_pkg::REG_CAPACITY: cap_r     <= cfg_data[vlsp_pkg::CAP_W-1:0];
        vlsp_pkg::REG_SESSION:  session_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opcode_r <= in_opcode;
      dt_r     <= in_elapsed_ms;
      kind_r   <= in_rx_kind;
      sid_r    <= in_rx_sender_id;
      alen_r   <= in_audio_length;
      fs_r     <= in_frame_size;
    end
  end

  // protocol state update
  always_comb begin
    link_nxt    = link_r;
    alive_nxt   = alive_r;
    id_nxt      = id_r;
    stamp_nxt   = stamp_r;
    ping_nxt    = ping_r;
    pong_nxt    = pong_r;
    respond_nxt = respond_r;
    if (cmd.set_initial) begin
      link_nxt = vlsp_pkg::LS_INITIAL;
    end
    if (cmd.set_idle) begin
      link_nxt = vlsp_pkg::LS_IDLE;
    end
    if (cmd.tick_sum) begin
      if (link_r == vlsp_pkg::LS_REQUESTING) begin
        respond_nxt = sat_add(respond_r, dt_r);
      end
      ping_nxt = sat_add(ping_r, dt_r);
      pong_nxt = sat_add(pong_r, dt_r);
    end
    if (cmd.tick_cmp) begin
      if (link_r == vlsp_pkg::LS_REQUESTING &&
          respond_r > {{(TW - vlsp_pkg::MS_W){1'b0}}, req_to_r}) begin
        respond_nxt = '0;
        link_nxt    = vlsp_pkg::LS_INITIAL;
      end
      if (ping_fire) begin
        ping_nxt = '0;
      end
      if (pong_r > {{(TW - vlsp_pkg::MS_W){1'b0}}, life_r}) begin
        pong_nxt = '0;
        link_nxt = vlsp_pkg::LS_INITIAL;
      end
    end
    if (cmd.emit) begin
      case (cmd.sel)
        vlsp_pkg::RES_REQ: link_nxt = vlsp_pkg::LS_REQUESTING;
        vlsp_pkg::RES_RX: begin
          if (link_r == vlsp_pkg::LS_REQUESTING) begin
            if (kind_r == vlsp_pkg::RX_GRANT) begin
              id_nxt   = sid_r;
              link_nxt = vlsp_pkg::LS_READY;
            end else if (kind_r == vlsp_pkg::RX_DENY) begin
              alive_nxt = 1'b0;
              link_nxt  = vlsp_pkg::LS_INITIAL;
            end
          end else if (rx_handled) begin
            pong_nxt = '0;
          end
        end
        vlsp_pkg::RES_VOICE: stamp_nxt = stamp_r + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r    <= vlsp_pkg::LS_IDLE;
      alive_r   <= 1'b1;
      id_r      <= '0;
      stamp_r   <= '0;
      ping_r    <= '0;
      pong_r    <= '0;
      respond_r <= '0;
    end else begin
      link_r    <= link_nxt;
      alive_r   <= alive_nxt;
      id_r      <= id_nxt;
      stamp_r   <= stamp_nxt;
      ping_r    <= ping_nxt;
      pong_r    <= pong_nxt;
      respond_r <= respond_nxt;
    end
  end

  // packetizer walk
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_len_r <= alen_r;
      pos_r     <= '0;
      cnt_r     <= '0;
    end else if (cmd.emit && cmd.sel == vlsp_pkg::RES_VOICE) begin
      rem_len_r <= rem_after;
      pos_r     <= pos_r + plen;
      cnt_r     <= cnt_r + 1'b1;
    end
    if (div_done) begin
      chunk_r <= cap_cl - div_rem;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_out_r    <= vlsp_pkg::SEND_NONE;
      sid_out_r     <= '0;
      stamp_out_r   <= '0;
      len_out_r     <= '0;
      off_out_r     <= '0;
      word_out_r    <= '0;
      handled_out_r <= 1'b0;
      last_out_r    <= 1'b1;
      case (cmd.sel)
        vlsp_pkg::RES_REQ: begin
          kind_out_r <= vlsp_pkg::SEND_REQUEST;
          len_out_r  <= vlsp_pkg::REQ_LEN;
          word_out_r <= session_r;
        end
        vlsp_pkg::RES_PING: begin
          kind_out_r <= vlsp_pkg::SEND_PING;
          sid_out_r  <= id_r;
        end
        vlsp_pkg::RES_RX: begin
          handled_out_r <= rx_handled;
        end
        vlsp_pkg::RES_VOICE: begin
          kind_out_r  <= vlsp_pkg::SEND_VOICE;
          sid_out_r   <= id_r;
          stamp_out_r <= stamp_r + 1'b1;
          len_out_r   <= plen[vlsp_pkg::CAP_W-1:0];
          off_out_r   <= pos_r;
          last_out_r  <= voice_last;
        end
        default: ;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_send_kind      = kind_out_r;
  assign out_sender_id      = sid_out_r;
  assign out_packet_stamp   = stamp_out_r;
  assign out_payload_length = len_out_r;
  assign out_payload_offset = off_out_r;
  assign out_request_word   = word_out_r;
  assign out_handled        = handled_out_r;
  assign out_last           = last_out_r;

  // never overwrite a result that has not been taken
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> slot_free)
    else $error("result register overwritten");

  a_voice_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_out_r == vlsp_pkg::SEND_VOICE) |->
      (len_out_r != '0 && !handled_out_r))
    else $error("voice data transfer with bad length or handled flag");

  a_req_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.sel == vlsp_pkg::RES_REQ) |=> link_r == vlsp_pkg::LS_REQUESTING)
    else $error("request sent without entering requesting");

  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.sel == vlsp_pkg::RES_VOICE) |=> stamp_r == $past(stamp_r) + 1'b1)
    else $error("stamp did not count up");

endmodule

// ===== rtl/vlsp_ctrl.sv =====
// sequencing state machine of the voice link sender
module vlsp_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  vlsp_pkg::sts_t sts,
  output vlsp_pkg::cmd_t cmd
);

  vlsp_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vlsp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vlsp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = vlsp_pkg::ST_DECODE;
        end
      end
      vlsp_pkg::ST_DECODE: begin
        state_nxt = vlsp_pkg::ST_IDLE;
        case (sts.opcode)
          vlsp_pkg::OP_TICK: begin
            if (sts.alive && sts.link == vlsp_pkg::LS_INITIAL) begin
              state_nxt = vlsp_pkg::ST_EMIT_REQ;
            end else if (sts.alive && sts.link != vlsp_pkg::LS_IDLE) begin
              state_nxt = vlsp_pkg::ST_TICK_SUM;
            end
          end
          vlsp_pkg::OP_RX: state_nxt = vlsp_pkg::ST_EMIT_RX;
          vlsp_pkg::OP_AUDIO: begin
            if (sts.alive && sts.link == vlsp_pkg::LS_READY && sts.audio_ok) begin
              state_nxt = vlsp_pkg::ST_DIV;
            end
          end
          default: ;
        endcase
      end
      vlsp_pkg::ST_TICK_SUM: state_nxt = vlsp_pkg::ST_TICK_CMP;
      vlsp_pkg::ST_TICK_CMP: begin
        state_nxt = sts.ping_fire ? vlsp_pkg::ST_EMIT_PING : vlsp_pkg::ST_IDLE;
      end
      vlsp_pkg::ST_EMIT_REQ, vlsp_pkg::ST_EMIT_PING, vlsp_pkg::ST_EMIT_RX: begin
        if (sts.slot_free) begin
          state_nxt = vlsp_pkg::ST_IDLE;
        end
      end
      vlsp_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = vlsp_pkg::ST_AUDIO;
        end
      end
      vlsp_pkg::ST_AUDIO: begin
        if (sts.slot_free && sts.voice_last) begin
          state_nxt = vlsp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vlsp_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    cmd.sel  = vlsp_pkg::RES_RX;
    in_ready = 1'b0;
    case (state_r)
      vlsp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      vlsp_pkg::ST_DECODE: begin
        case (sts.opcode)
          vlsp_pkg::OP_PEER:     cmd.set_initial = 1'b1;
          vlsp_pkg::OP_SHUTDOWN: cmd.set_idle = 1'b1;
          vlsp_pkg::OP_AUDIO: begin
            cmd.div_start = sts.alive && sts.link == vlsp_pkg::LS_READY && sts.audio_ok;
          end
          default: ;
        endcase
      end
      vlsp_pkg::ST_TICK_SUM: cmd.tick_sum = 1'b1;
      vlsp_pkg::ST_TICK_CMP: cmd.tick_cmp = 1'b1;
      vlsp_pkg::ST_EMIT_REQ: begin
        cmd.emit = sts.slot_free;
        cmd.sel  = vlsp_pkg::RES_REQ;
      end
      vlsp_pkg::ST_EMIT_PING: begin
        cmd.emit = sts.slot_free;
        cmd.sel  = vlsp_pkg::RES_PING;
      end
      vlsp_pkg::ST_EMIT_RX: begin
        cmd.emit = sts.slot_free;
        cmd.sel  = vlsp_pkg::RES_RX;
      end
      vlsp_pkg::ST_AUDIO: begin
        cmd.emit = sts.slot_free;
        cmd.sel  = vlsp_pkg::RES_VOICE;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/voice_link_sender_protocol_top.sv =====
// top level of the voice link sender: control protocol and audio packetizer
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+--------------------------
//  in      | in_valid/in_ready, six item fields         | in_valid & in_ready
//  out     | out_valid/out_ready, eight result fields   | out_valid & out_ready
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data   | cfg_valid & cfg_ready
//
//  sequence: one item at a time; accept, then decode. tick: sum, compare, ping if
//  due (request at once if initial); received packet: one result; peer/shutdown:
//  decode only; audio: remainder unit (11 bit steps), then the voice packets
//  reset: rst_n synchronous, active low; no clearing pass, ready right after
//  stalls: a held result register stops the sequencer only when it must emit;
//  cfg always ready; user must write it only while the block is idle (unchecked)
module voice_link_sender_protocol_top (
  input  logic        clk,
  input  logic        rst_n,
  // item channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [15:0] in_elapsed_ms,
  input  logic [1:0]  in_rx_kind,
  input  logic [15:0] in_rx_sender_id,
  input  logic [11:0] in_audio_length,
  input  logic [10:0] in_frame_size,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_send_kind,
  output logic [15:0] out_sender_id,
  output logic [31:0] out_packet_stamp,
  output logic [10:0] out_payload_length,
  output logic [11:0] out_payload_offset,
  output logic [31:0] out_request_word,
  output logic        out_handled,
  output logic        out_last,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  vlsp_pkg::cmd_t cmd;
  vlsp_pkg::sts_t sts;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: decodes the item, steps timers, drives the packet walk
  vlsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: link state, timers, remainder unit and result register
  vlsp_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_opcode          (in_opcode),
    .in_elapsed_ms      (in_elapsed_ms),
    .in_rx_kind         (in_rx_kind),
    .in_rx_sender_id    (in_rx_sender_id),
    .in_audio_length    (in_audio_length),
    .in_frame_size      (in_frame_size),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_send_kind      (out_send_kind),
    .out_sender_id      (out_sender_id),
    .out_packet_stamp   (out_packet_stamp),
    .out_payload_length (out_payload_length),
    .out_payload_offset (out_payload_offset),
    .out_request_word   (out_request_word),
    .out_handled        (out_handled),
    .out_last           (out_last)
  );

endmodule

// ===== dv/tb_voice_link_sender_protocol_top.sv =====
// self-checking testbench of the voice link sender: directed table, random traffic, scoreboard
`timescale 1ns / 1ps

module tb_voice_link_sender_protocol_top;
  import vlsp_pkg::*;

  // run control
  localparam int SETTLE_CYCLES = 40;      // covers the slowest item that sends nothing
  localparam int CYCLE_LIMIT   = 400000;  // far above the slowest correct run
  localparam int PHASES        = 4;
  localparam int PHASE_ITEMS   = 50;      // random items per configuration phase
  localparam int IDLE_PCT      = 18;

  // how a directed row gets its expected sends
  typedef enum {ROW_PREDICT, ROW_NONE, ROW_ONE} row_mode_t;

  typedef struct packed {
    send_kind_t  send_kind;
    logic [15:0] sender_id;
    logic [31:0] packet_stamp;
    logic [10:0] payload_length;
    logic [11:0] payload_offset;
    logic [31:0] request_word;
    logic        handled;
    logic        last;
  } send_t;

  typedef struct {
    logic [2:0]  opcode;
    logic [15:0] dt;
    logic [1:0]  kind;
    logic [15:0] sid;
    logic [11:0] alen;
    logic [10:0] fs;
    row_mode_t   mode;
    send_t       res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_opcode;
  logic [15:0] in_elapsed_ms;
  logic [1:0]  in_rx_kind;
  logic [15:0] in_rx_sender_id;
  logic [11:0] in_audio_length;
  logic [10:0] in_frame_size;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_send_kind;
  logic [15:0] out_sender_id;
  logic [31:0] out_packet_stamp;
  logic [10:0] out_payload_length;
  logic [11:0] out_payload_offset;
  logic [31:0] out_request_word;
  logic        out_handled;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  voice_link_sender_protocol_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_elapsed_ms      (in_elapsed_ms),
    .in_rx_kind         (in_rx_kind),
    .in_rx_sender_id    (in_rx_sender_id),
    .in_audio_length    (in_audio_length),
    .in_frame_size      (in_frame_size),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_send_kind      (out_send_kind),
    .out_sender_id      (out_sender_id),
    .out_packet_stamp   (out_packet_stamp),
    .out_payload_length (out_payload_length),
    .out_payload_offset (out_payload_offset),
    .out_request_word   (out_request_word),
    .out_handled        (out_handled),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sends still owed by the block, oldest first
  send_t expected_sends[$];
  row_t  dir_rows[$];
  int    n_head;
  int    errors = 0;
  int    cycle_cnt = 0;
  bit    keep_pred = 1'b1;  // cleared while a typed row overrides the prediction
  bit    calm = 1'b0;       // no idling on either side while set

  // shadow copy of the link: registers and protocol state
  logic [15:0] cfg_lifesign = LIFESIGN_RST;
  logic [15:0] cfg_req_to   = REQ_TO_RST;
  logic [10:0] cfg_capacity = CAP_RST;
  logic [31:0] cfg_session  = '0;
  link_t       m_link       = LS_IDLE;
  logic        m_alive      = 1'b1;
  logic [15:0] m_peer_id    = '0;
  logic [31:0] m_stamp      = '0;
  logic [31:0] m_ping_ms    = '0;
  logic [31:0] m_pong_ms    = '0;
  logic [31:0] m_resp_ms    = '0;

  function automatic send_t mk_send(send_kind_t kind, logic [15:0] sid, logic [31:0] stamp,
                                    logic [10:0] len, logic [11:0] off, logic [31:0] word,
                                    logic handled, logic last);
    send_t s;
    s.send_kind      = kind;
    s.sender_id      = sid;
    s.packet_stamp   = stamp;
    s.payload_length = len;
    s.payload_offset = off;
    s.request_word   = word;
    s.handled        = handled;
    s.last           = last;
    return s;
  endfunction

  function automatic row_t mk_row(logic [2:0] op, logic [15:0] dt, logic [1:0] kind,
                                  logic [15:0] sid, logic [11:0] alen, logic [10:0] fs,
                                  row_mode_t mode, send_t res);
    row_t r;
    r.opcode = op;
    r.dt     = dt;
    r.kind   = kind;
    r.sid    = sid;
    r.alen   = alen;
    r.fs     = fs;
    r.mode   = mode;
    r.res    = res;
    return r;
  endfunction

  // timers stop at the top of 32 bits
  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic owe_send(input send_t s);
    if (keep_pred) expected_sends.push_back(s);
  endtask

  // advance the shadow link by one accepted item and queue the sends it causes
  task automatic predict_link_item(input row_t it);
    int unsigned cap, fs, rem, pos, chunk, plen, n;
    logic        handled;
    case (it.opcode)
      OP_TICK: begin
        // dead or idle link ignores ticks
        if (m_alive && m_link != LS_IDLE) begin
          if (m_link == LS_INITIAL) begin
            owe_send(mk_send(SEND_REQUEST, '0, '0, REQ_LEN, '0, cfg_session, 1'b0, 1'b1));
            m_link = LS_REQUESTING;
          end else begin
            if (m_link == LS_REQUESTING) begin
              m_resp_ms = sat_add32(m_resp_ms, it.dt);
              if (m_resp_ms > {16'b0, cfg_req_to}) begin
                m_resp_ms = '0;
                m_link    = LS_INITIAL;
              end
            end
            // ping every fifth of the lifesign period, also while requesting
            m_ping_ms = sat_add32(m_ping_ms, it.dt);
            if (({32'b0, m_ping_ms} * 64'd5) > {48'b0, cfg_lifesign}) begin
              m_ping_ms = '0;
              owe_send(mk_send(SEND_PING, m_peer_id, '0, '0, '0, '0, 1'b0, 1'b1));
            end
            m_pong_ms = sat_add32(m_pong_ms, it.dt);
            if (m_pong_ms > {16'b0, cfg_lifesign}) begin
              m_pong_ms = '0;
              m_link    = LS_INITIAL;
            end
          end
        end
      end
      OP_PEER: m_link = LS_INITIAL;
      OP_RX: begin
        // alive is not looked at here
        handled = 1'b0;
        if (m_link == LS_REQUESTING) begin
          if (it.kind == RX_GRANT) begin
            m_peer_id = it.sid;
            m_link    = LS_READY;
            handled   = 1'b1;
          end else if (it.kind == RX_DENY) begin
            m_alive = 1'b0;
            m_link  = LS_INITIAL;
            handled = 1'b1;
          end
        end else if (m_link == LS_READY && it.kind == RX_PONG && it.sid == m_peer_id) begin
          m_pong_ms = '0;
          handled   = 1'b1;
        end
        owe_send(mk_send(SEND_NONE, '0, '0, '0, '0, '0, handled, 1'b1));
      end
      OP_AUDIO: begin
        cap = cfg_capacity;
        if (cap < CAP_MIN) cap = CAP_MIN;
        if (cap > MAX_PAYLOAD) cap = MAX_PAYLOAD;
        fs  = it.fs;
        rem = it.alen;
        pos = 0;
        n   = 0;
        if (m_link == LS_READY && m_alive && fs != 0 && fs <= cap) begin
          // packets carry whole frames, as many as fit in the capacity
          chunk = (cap / fs) * fs;
          while (rem >= fs && n < MAX_RESULTS) begin
            plen    = (chunk < rem) ? chunk : rem;
            m_stamp = m_stamp + 32'd1;
            owe_send(mk_send(SEND_VOICE, m_peer_id, m_stamp, 11'(plen), 12'(pos), '0, 1'b0,
                             (rem - plen < fs) || (n + 1 == MAX_RESULTS)));
            n   = n + 1;
            rem = rem - plen;
            pos = pos + plen;
          end
        end
      end
      OP_SHUTDOWN: m_link = LS_IDLE;
      default: ;
    endcase
  endtask

  // present one item, hold it until the transfer, then predict; valid stays up
  task automatic send_item(input row_t it);
    in_valid        <= 1'b1;
    in_opcode       <= it.opcode;
    in_elapsed_ms   <= it.dt;
    in_rx_kind      <= it.kind;
    in_rx_sender_id <= it.sid;
    in_audio_length <= it.alen;
    in_frame_size   <= it.fs;
    do @(posedge clk); while (!in_ready);
    keep_pred = (it.mode == ROW_PREDICT);
    predict_link_item(it);
    keep_pred = 1'b1;
    if (it.mode == ROW_ONE) expected_sends.push_back(it.res);
  endtask

  // random sender gap
  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // stop sending, wait for every owed send, then let the block go quiet
  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    while (expected_sends.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // one register write; cfg_valid stays up for a following write
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LIFESIGN: cfg_lifesign = val[15:0];
      REG_REQ_TO:   cfg_req_to   = val[15:0];
      REG_CAPACITY: cfg_capacity = val[10:0];
      REG_SESSION:  cfg_session  = val;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_cnt, what, got, want);
    errors++;
  endtask

  // receiver stalls at random, never during the calm stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // scoreboard: every transfer on the result channel against the oldest owed send
  send_t want;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_sends.size() == 0) begin
        report_mismatch("send with nothing owed, kind", {30'b0, out_send_kind}, '0);
      end else begin
        want = expected_sends.pop_front();
        if (out_send_kind !== want.send_kind)
          report_mismatch("send_kind", {30'b0, out_send_kind}, {30'b0, want.send_kind});
        if (out_sender_id !== want.sender_id)
          report_mismatch("sender_id", {16'b0, out_sender_id}, {16'b0, want.sender_id});
        if (out_packet_stamp !== want.packet_stamp)
          report_mismatch("packet_stamp", out_packet_stamp, want.packet_stamp);
        if (out_payload_length !== want.payload_length)
          report_mismatch("payload_length", {21'b0, out_payload_length},
                          {21'b0, want.payload_length});
        if (out_payload_offset !== want.payload_offset)
          report_mismatch("payload_offset", {20'b0, out_payload_offset},
                          {20'b0, want.payload_offset});
        if (out_request_word !== want.request_word)
          report_mismatch("request_word", out_request_word, want.request_word);
        if (out_handled !== want.handled)
          report_mismatch("handled", {31'b0, out_handled}, {31'b0, want.handled});
        if (out_last !== want.last)
          report_mismatch("last", {31'b0, out_last}, {31'b0, want.last});
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    row_t        rr;
    int          r;
    int          s;
    logic [31:0] phase_val [4];

    in_valid        = 1'b0;
    in_opcode       = '0;
    in_elapsed_ms   = '0;
    in_rx_kind      = '0;
    in_rx_sender_id = '0;
    in_audio_length = '0;
    in_frame_size   = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    rst_n           = 1'b0;

    // directed head, register reset values in force
    // idle link: tick does nothing, packet is answered unhandled, audio sends nothing
    dir_rows.push_back(mk_row(OP_TICK, 16'hFFFF, RX_GRANT, 16'h0000, 12'h000, 11'd0,
                              ROW_NONE, '0));
    dir_rows.push_back(mk_row(OP_RX, 16'h0000, RX_GRANT, 16'hFFFF, 12'h000, 11'd0, ROW_ONE,
                              mk_send(SEND_NONE, '0, '0, '0, '0, '0, 1'b0, 1'b1)));
    dir_rows.push_back(mk_row(OP_AUDIO, 16'h0000, RX_GRANT, 16'h0000, 12'hFFF, 11'd1,
                              ROW_NONE, '0));
    // unused opcodes, one with every field at its top
    dir_rows.push_back(mk_row(3'd5, 16'h0000, RX_GRANT, 16'h0000, 12'h000, 11'd0,
                              ROW_NONE, '0));
    dir_rows.push_back(mk_row(3'd7, 16'hFFFF, RX_OTHER, 16'hFFFF, 12'hFFF, 11'h7FF,
                              ROW_NONE, '0));
    dir_rows.push_back(mk_row(OP_SHUTDOWN, 16'h0000, RX_GRANT, 16'h0000, 12'h000, 11'd0,
                              ROW_NONE, '0));
    dir_rows.push_back(mk_row(OP_PEER, 16'h0000, RX_GRANT, 16'h0000, 12'h000, 11'd0,
                              ROW_NONE, '0));
    // first tick in initial sends the connection request with the reset session id
    dir_rows.push_back(mk_row(OP_TICK, 16'h0000, RX_GRANT, 16'h0000, 12'h000, 11'd0, ROW_ONE,
                              mk_send(SEND_REQUEST, '0, '0, REQ_LEN, '0, '0, 1'b0, 1'b1)));
    dir_rows.push_back(mk_row(OP_RX, 16'h0000, RX_PONG, 16'h0000, 12'h000, 11'd0,
                              ROW_PREDICT, '0));
    dir_rows.push_back(mk_row(OP_RX, 16'h0000, RX_OTHER, 16'hFFFF, 12'h000, 11'd0,
                              ROW_PREDICT, '0));
    // respond timeout, then a ping while still requesting
    dir_rows.push_back(mk_row(OP_TICK, 16'd1000, RX_GRANT, 16'h0000, 12'h000, 11'd0,
                              ROW_PREDICT, '0));
    dir_rows.push_back(mk_row(OP_TICK, 16'd0, RX_GRANT, 16'h0000, 12'h000, 11'd0,
                              ROW_PREDICT, '0));
    dir_rows.push_back(mk_row(OP_TICK, 16'd1001, RX_GRANT, 16'h0000, 12'h000, 11'd0,
                              ROW_PREDICT, '0));
    dir_rows.push_back(mk_row(OP_TICK, 16'd0, RX_GRANT, 16'h0000, 12'h000, 11'd0,
                              ROW_PREDICT, '0));
    dir_rows.push_back(mk_row(OP_RX, 16'h0000, RX_GRANT, 16'hA5C3, 12'h000, 11'd0,
                              ROW_PREDICT, '0));
    // audio: smallest and largest frames, zero frame and frame above capacity
    dir_rows.push_back(mk_row(OP_AUDIO, 16'h0000, RX_GRANT, 16'h0000, 12'hFFF, 11'd1,
                              ROW_PREDICT, '0));
    dir_rows.push_back(mk_row(OP_AUDIO, 16'h0000, RX_GRANT, 16'h0000, 12'hFFF, 11'd1024,
                              ROW_PREDICT, '0));
    dir_rows.push_back(mk_row(OP_AUDIO, 16'h0000, RX_GRANT, 16'h0000, 12'hFFF, 11'd0,
                              ROW_NONE, '0));
    dir_rows.push_back(mk_row(OP_AUDIO, 16'h0000, RX_GRANT, 16'h0000, 12'hFFF, 11'h7FF,
                              ROW_NONE, '0));
    dir_rows.push_back(mk_row(OP_AUDIO, 16'h0000, RX_GRANT, 16'h0000, 12'd100, 11'd7,
                              ROW_PREDICT, '0));
    // pongs with matching and foreign id, deny while ready
    dir_rows.push_back(mk_row(OP_RX, 16'h0000, RX_PONG, 16'hA5C3, 12'h000, 11'd0,
                              ROW_PREDICT, '0));
    dir_rows.push_back(mk_row(OP_RX, 16'h0000, RX_PONG, 16'h0000, 12'h000, 11'd0,
                              ROW_PREDICT, '0));
    dir_rows.push_back(mk_row(OP_RX, 16'h0000, RX_DENY, 16'h0000, 12'h000, 11'd0,
                              ROW_PREDICT, '0));
    // longest tick: ping plus pong timeout
    dir_rows.push_back(mk_row(OP_TICK, 16'hFFFF, RX_GRANT, 16'h0000, 12'h000, 11'd0,
                              ROW_PREDICT, '0));
    dir_rows.push_back(mk_row(OP_RX, 16'h0000, RX_GRANT, 16'h1234, 12'h000, 11'd0,
                              ROW_PREDICT, '0));
    n_head = dir_rows.size();
    // directed tail: a deny while requesting kills the link for good, so it comes last
    dir_rows.push_back(mk_row(OP_PEER, 16'h0000, RX_GRANT, 16'h0000, 12'h000, 11'd0,
                              ROW_PREDICT, '0));
    dir_rows.push_back(mk_row(OP_TICK, 16'h0000, RX_GRANT, 16'h0000, 12'h000, 11'd0,
                              ROW_PREDICT, '0));
    dir_rows.push_back(mk_row(OP_RX, 16'h0000, RX_DENY, 16'h0000, 12'h000, 11'd0, ROW_ONE,
                              mk_send(SEND_NONE, '0, '0, '0, '0, '0, 1'b1, 1'b1)));
    dir_rows.push_back(mk_row(OP_TICK, 16'hFFFF, RX_GRANT, 16'h0000, 12'h000, 11'd0,
                              ROW_NONE, '0));
    dir_rows.push_back(mk_row(OP_PEER, 16'h0000, RX_GRANT, 16'h0000, 12'h000, 11'd0,
                              ROW_PREDICT, '0));
    dir_rows.push_back(mk_row(OP_TICK, 16'd10, RX_GRANT, 16'h0000, 12'h000, 11'd0,
                              ROW_NONE, '0));
    // packets are still looked at while dead
    dir_rows.push_back(mk_row(OP_RX, 16'h0000, RX_GRANT, 16'h0042, 12'h000, 11'd0,
                              ROW_PREDICT, '0));
    dir_rows.push_back(mk_row(OP_AUDIO, 16'h0000, RX_GRANT, 16'h0000, 12'd500, 11'd10,
                              ROW_NONE, '0));

    // reset once
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < n_head; i++) begin
      maybe_gap();
      send_item(dir_rows[i]);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // block must be quiet before its registers change
      wait_drained(SETTLE_CYCLES);
      case (ph)
        0: phase_val = '{32'd65535, 32'd65535, 32'd2047, 32'hFFFF_FFFF};
        1: phase_val = '{32'd5, 32'd1, 32'd0, 32'd0};
        2: phase_val = '{$urandom_range(5, 65535), $urandom_range(1, 65535),
                         $urandom_range(64, 1024), $urandom};
        default: phase_val = '{32'd300, 32'd50, 32'd64, $urandom};
      endcase
      for (int k = 0; k < 4; k++) write_reg(reg_idx_t'(k), phase_val[k]);
      cfg_valid <= 1'b0;

      for (int j = 0; j < PHASE_ITEMS; j++) begin
        // long stretch without idling on either side
        calm = (ph == 2 && j < 30);
        // sender holds off until everything owed has come back
        if (ph == 0 && j == 25) wait_drained(0);
        maybe_gap();

        // start from noise on every field, then steer most items along the protocol
        rr = mk_row(3'($urandom_range(0, 7)), 16'($urandom), 2'($urandom), 16'($urandom),
                    12'($urandom), 11'($urandom), ROW_PREDICT, '0);
        r = $urandom_range(0, 99);
        s = $urandom_range(0, 99);
        if (r >= 15) begin
          if ($urandom_range(0, 9) != 0)
            rr.dt = 16'($urandom_range(0, cfg_lifesign / 4 + 1));
          if ($urandom_range(0, 9) != 0)
            rr.fs = 11'($urandom_range(1, 96));
          case (m_link)
            LS_IDLE:       rr.opcode = (s < 80) ? OP_PEER : OP_TICK;
            LS_INITIAL:    rr.opcode = (s < 92) ? OP_TICK : OP_SHUTDOWN;
            LS_REQUESTING: begin
              if (s < 70) begin
                rr.opcode = OP_RX;
                rr.kind   = RX_GRANT;
              end else if (s < 90) begin
                rr.opcode = OP_TICK;
              end else begin
                rr.opcode = OP_RX;
              end
            end
            default: begin
              if (s < 60) begin
                rr.opcode = OP_AUDIO;
              end else if (s < 78) begin
                rr.opcode = OP_TICK;
              end else if (s < 92) begin
                rr.opcode = OP_RX;
                rr.kind   = RX_PONG;
                if ($urandom_range(0, 3) != 0) rr.sid = m_peer_id;
              end else if (s < 96) begin
                rr.opcode = OP_SHUTDOWN;
              end else begin
                rr.opcode = OP_PEER;
              end
            end
          endcase
        end
        // keep the link alive: the only deny that kills it is in the tail
        if (rr.opcode == OP_RX && rr.kind == RX_DENY && m_link == LS_REQUESTING)
          rr.kind = RX_OTHER;
        send_item(rr);
      end
    end
    calm = 1'b0;

    for (int i = n_head; i < dir_rows.size(); i++) begin
      maybe_gap();
      send_item(dir_rows[i]);
    end

    wait_drained(SETTLE_CYCLES);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
